// ===== rtl/ktr_pkg.sv =====
// shared types and constants for the keyboard typematic repeat engine
`timescale 1ns / 1ps

package ktr_pkg;

   // item field widths
   localparam int KEY_W      = 8;
   localparam int TIME_W     = 32;
   localparam int DELAY_W    = 12;
   localparam int PERIOD_W   = 10;
   localparam int COUNT_W    = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_DATA_W = 12;

   // key state byte: bit 7 marks a press
   localparam int PRESS_BIT = 7;

   // register reset values
   localparam logic [DELAY_W-1:0]  DELAY_RESET  = 12'd250;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd150;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // one scan emits at most this many results
   localparam int MAX_RESULTS  = 8;
   localparam int RESULT_CNT_W = 4;

   // restoring divider, one quotient bit per cycle
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = 5;

   typedef enum logic [1:0] {
      OP_KEY   = 2'd0,
      OP_SCAN  = 2'd1,
      OP_FLUSH = 2'd2
   } opcode_type;

   typedef enum logic {
      CSR_DELAY  = 1'b0,
      CSR_PERIOD = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_SCAN_CHECK,
      ST_DIVIDE,
      ST_SCAN_TAKE,
      ST_SCAN_END
   } state_type;

   typedef struct packed {
      logic accept;
      logic flush;
      logic key_apply;
      logic scan_start;
      logic scan_next;
      logic div_start;
      logic div_step;
      logic scan_take;
      logic push_last;
   } cmd_type;

   typedef struct packed {
      opcode_type in_opcode;
      logic       press;
      logic       out_free;
      logic       scan_done;
      logic       slot_hit;
      logic       div_done;
      logic       quot_zero;
      logic       pend_valid;
   } status_type;

endpackage

// ===== rtl/ktr_datapath.sv =====
// datapath: held-key table, config registers, divider, pending and output registers
`timescale 1ns / 1ps

module ktr_datapath #(
   parameter int HELD_SLOTS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [ktr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ktr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [ktr_pkg::CSR_DATA_W-1:0] csr_data,
   input  ktr_pkg::cmd_type               cmd,
   output ktr_pkg::status_type            status
);
   import ktr_pkg::*;

   localparam int IDX_W = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
   localparam int CNT_W = $clog2(HELD_SLOTS + 1);

   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic [PERIOD_W-1:0] period_ff, period_in;

   logic [HELD_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [KEY_W-1:0]      slot_key_ff [HELD_SLOTS];
   logic [KEY_W-1:0]      slot_key_in [HELD_SLOTS];
   logic [TIME_W-1:0]     slot_deadline_ff [HELD_SLOTS];
   logic [TIME_W-1:0]     slot_deadline_in [HELD_SLOTS];

   logic [KEY_W-1:0]  item_key_ff, item_key_in;
   logic [KEY_W-1:0]  item_state_ff, item_state_in;
   logic [TIME_W-1:0] item_time_ff, item_time_in;

   logic [CNT_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [RESULT_CNT_W-1:0] found_ff, found_in;

   logic [TIME_W-1:0]    div_ff, div_in;
   logic [PERIOD_W-1:0]  rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic               pend_valid_ff, pend_valid_in;
   logic [KEY_W-1:0]   pend_key_ff, pend_key_in;
   logic [COUNT_W-1:0] pend_count_ff, pend_count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_rep_ff, rsp_rep_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [PERIOD_W-1:0] period_eff;
   logic [IDX_W-1:0]    idx;
   logic [TIME_W-1:0]   cur_deadline;
   logic [KEY_W-1:0]    cur_key;
   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W:0]   trial_diff;
   logic                trial_ge;
   logic [COUNT_W-1:0]  quot_sat;
   logic                out_free;

   logic [HELD_SLOTS-1:0] hit_vec, free_vec;
   logic [IDX_W-1:0]      hit_idx, free_idx;
   logic                  hit_any, free_any;

   assign csr_ready  = 1'b1;
   assign period_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign idx        = scan_idx_ff[IDX_W-1:0];
   assign cur_deadline = slot_deadline_ff[idx];
   assign cur_key      = slot_key_ff[idx];

   // restoring divide step
   assign trial      = {rem_ff, div_ff[TIME_W-1]};
   assign trial_ge   = (trial >= {1'b0, period_eff});
   assign trial_diff = trial - {1'b0, period_eff};
   assign quot_sat   = (div_ff[TIME_W-1:COUNT_W] != '0) ? COUNT_MAX : div_ff[COUNT_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;

   // associative match and lowest free slot
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < HELD_SLOTS; i++) begin
         hit_vec[i]  = slot_valid_ff[i] && (slot_key_ff[i] == item_key_ff);
         free_vec[i] = !slot_valid_ff[i];
      end
      for (int i = HELD_SLOTS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (free_vec[i]) begin
            free_idx = IDX_W'(i);
         end
      end
      hit_any  = |hit_vec;
      free_any = |free_vec;
   end

   always_comb begin
      delay_in         = delay_ff;
      period_in        = period_ff;
      slot_valid_in    = slot_valid_ff;
      slot_key_in      = slot_key_ff;
      slot_deadline_in = slot_deadline_ff;
      item_key_in      = item_key_ff;
      item_state_in    = item_state_ff;
      item_time_in     = item_time_ff;
      scan_idx_in      = scan_idx_ff;
      found_in         = found_ff;
      div_in           = div_ff;
      rem_in           = rem_ff;
      div_cnt_in       = div_cnt_ff;
      pend_valid_in    = pend_valid_ff;
      pend_key_in      = pend_key_ff;
      pend_count_in    = pend_count_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_key_in       = rsp_key_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_rep_in       = rsp_rep_ff;
      rsp_last_in      = rsp_last_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELAY:  delay_in  = csr_data;
            CSR_PERIOD: period_in = csr_data[PERIOD_W-1:0];
            default:    delay_in  = delay_ff;
         endcase
      end

      if (cmd.accept) begin
         item_key_in   = req_tdata[KEY_W-1:0];
         item_state_in = req_tdata[2*KEY_W-1:KEY_W];
         item_time_in  = req_tdata[REQ_DATA_W-1:2*KEY_W];
      end

      if (cmd.flush) begin
         slot_valid_in = '0;
      end

      if (cmd.key_apply) begin
         if (item_state_ff[PRESS_BIT]) begin
            if (hit_any) begin
               slot_deadline_in[hit_idx] = item_time_ff + TIME_W'(delay_ff);
            end else if (free_any) begin
               slot_valid_in[free_idx]    = 1'b1;
               slot_key_in[free_idx]      = item_key_ff;
               slot_deadline_in[free_idx] = item_time_ff + TIME_W'(delay_ff);
            end
            rsp_valid_in = 1'b1;
            rsp_key_in   = item_key_ff;
            rsp_count_in = COUNT_W'(1);
            rsp_rep_in   = 1'b0;
            rsp_last_in  = 1'b1;
         end else if (hit_any) begin
            slot_valid_in[hit_idx] = 1'b0;
         end
      end

      if (cmd.scan_start) begin
         scan_idx_in   = '0;
         found_in      = '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.scan_next) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
      end

      if (cmd.div_start) begin
         div_in     = item_time_ff - cur_deadline;
         rem_in     = '0;
         div_cnt_in = '0;
      end

      if (cmd.div_step) begin
         div_in     = {div_ff[TIME_W-2:0], trial_ge};
         rem_in     = trial_ge ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end

      // deadline + quotient * period equals now - remainder
      if (cmd.scan_take) begin
         slot_deadline_in[idx] = item_time_ff - TIME_W'(rem_ff);
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = pend_key_ff;
            rsp_count_in = pend_count_ff;
            rsp_rep_in   = 1'b1;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_key_in   = cur_key;
         pend_count_in = quot_sat;
         found_in      = found_ff + RESULT_CNT_W'(1);
         scan_idx_in   = scan_idx_ff + CNT_W'(1);
      end

      if (cmd.push_last) begin
         rsp_valid_in  = 1'b1;
         rsp_key_in    = pend_key_ff;
         rsp_count_in  = pend_count_ff;
         rsp_rep_in    = 1'b1;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff      <= DELAY_RESET;
         period_ff     <= PERIOD_RESET;
         slot_valid_ff <= '0;
         scan_idx_ff   <= '0;
         found_ff      <= '0;
         div_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         delay_ff      <= delay_in;
         period_ff     <= period_in;
         slot_valid_ff <= slot_valid_in;
         scan_idx_ff   <= scan_idx_in;
         found_ff      <= found_in;
         div_cnt_ff    <= div_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_key_ff      <= slot_key_in;
      slot_deadline_ff <= slot_deadline_in;
      item_key_ff      <= item_key_in;
      item_state_ff    <= item_state_in;
      item_time_ff     <= item_time_in;
      div_ff           <= div_in;
      rem_ff           <= rem_in;
      pend_key_ff      <= pend_key_in;
      pend_count_ff    <= pend_count_in;
      rsp_key_ff       <= rsp_key_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_rep_ff       <= rsp_rep_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_key_ff};
   assign rsp_tuser  = rsp_rep_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      status.in_opcode  = opcode_type'(req_tuser);
      status.press      = item_state_ff[PRESS_BIT];
      status.out_free   = out_free;
      status.scan_done  = (scan_idx_ff == CNT_W'(HELD_SLOTS)) ||
                          (found_ff == RESULT_CNT_W'(MAX_RESULTS));
      status.slot_hit   = slot_valid_ff[idx] && (item_time_ff > cur_deadline);
      status.div_done   = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
      status.quot_zero  = (div_ff == '0);
      status.pend_valid = pend_valid_ff;
   end

endmodule

// ===== rtl/ktr_controller.sv =====
// controller: sequences key events, table scans and the divider
`timescale 1ns / 1ps

module ktr_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  ktr_pkg::status_type status,
   output ktr_pkg::cmd_type    cmd
);
   import ktr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (status.in_opcode)
                  OP_KEY:   state_in = ST_KEY;
                  OP_SCAN:  state_in = ST_SCAN_CHECK;
                  OP_FLUSH: state_in = ST_IDLE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_KEY: begin
            if (!status.press || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_CHECK: begin
            if (status.scan_done) begin
               state_in = ST_SCAN_END;
            end else if (status.slot_hit) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_SCAN_TAKE;
            end
         end
         ST_SCAN_TAKE: begin
            if (status.quot_zero || !status.pend_valid || status.out_free) begin
               state_in = ST_SCAN_CHECK;
            end
         end
         ST_SCAN_END: begin
            if (!status.pend_valid || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (status.in_opcode)
                  OP_KEY:   cmd.accept     = 1'b1;
                  OP_SCAN:  cmd.scan_start = 1'b1;
                  OP_FLUSH: cmd.flush      = 1'b1;
                  default:  cmd.accept     = 1'b1;
               endcase
            end
         end
         ST_KEY: begin
            if (!status.press || status.out_free) begin
               cmd.key_apply = 1'b1;
            end
         end
         ST_SCAN_CHECK: begin
            if (!status.scan_done) begin
               if (status.slot_hit) begin
                  cmd.div_start = 1'b1;
               end else begin
                  cmd.scan_next = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_SCAN_TAKE: begin
            if (status.quot_zero) begin
               cmd.scan_next = 1'b1;
            end else if (!status.pend_valid || status.out_free) begin
               cmd.scan_take = 1'b1;
            end
         end
         ST_SCAN_END: begin
            if (status.pend_valid && status.out_free) begin
               cmd.push_last = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/keyboard_typematic_repeat.sv =====
// top level of the keyboard typematic repeat engine
// key items apply in ST_KEY, a press with its click item once the output is free; flush
//   clears the table on accept; a scan walks ST_SCAN_CHECK per slot, runs the serial
//   divider in ST_DIVIDE for a due slot, takes it in ST_SCAN_TAKE, closes in ST_SCAN_END
// throughput is set by the single restoring divider shared by all slots of the table
// reset: synchronous, active high; clears the held-key table, the output register and
//   loads repeat delay 250 ms and repeat period 150 ms
`timescale 1ns / 1ps

module keyboard_typematic_repeat #(
   parameter int HELD_SLOTS = 8   // held-key table depth, 1 to 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // input items
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [7:0] key_code, [15:8] key_state, [47:16] time_ms
   input  logic [ktr_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]                     req_tuser,
   // result items
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] out_key, [23:8] click_count
   output logic [ktr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] is_repeat
   output logic                           rsp_tuser,
   // last_of_run
   output logic                           rsp_tlast,
   // register writes: index 0 repeat_delay_ms, index 1 repeat_period_ms
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [ktr_pkg::CSR_DATA_W-1:0] csr_data
);
   import ktr_pkg::*;

   // command and status between the sequencer and the datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: one item at a time, walks the table and runs the divider
   ktr_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // table, config, divider, pending result and output register
   // the output register lets the next item in while a result waits
   ktr_datapath #(
      .HELD_SLOTS (HELD_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
